FILE: sv/ps2_mouse_packet_decoder_top_assert.svh
// Assertion shorthands for the mouse packet decoder.
// All of them sample on clk and are off while arst_n is low.
`ifndef PS2_MOUSE_PACKET_DECODER_TOP_ASSERT_SVH
`define PS2_MOUSE_PACKET_DECODER_TOP_ASSERT_SVH

// cond must never hold
`define PMPD_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// ante implies cons in the same cycle
`define PMPD_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the next cycle
`define PMPD_IMPLY_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/pmpd_pkg.sv
`timescale 1ns / 1ps

package pmpd_pkg;

	// cursor register width default
	localparam int POSITION_BITS_DEF = 12;

	// field and bus widths
	localparam int SIZE_W    = 13;
	localparam int POS_OUT_W = 12;
	localparam int DELTA_W   = 8;
	localparam int BTN_W     = 3;
	localparam int DATA_W    = 32;
	localparam int PADDR_W   = 3;

	// register reset values
	localparam int RESET_WIDTH  = 1024;
	localparam int RESET_HEIGHT = 768;

	// register index, taken from paddr[2]
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	// transaction opcodes
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// bit positions inside the first byte of a packet
	localparam int SYNC_BIT  = 3;
	localparam int XSIGN_BIT = 4;
	localparam int YSIGN_BIT = 5;
	localparam int XOVF_BIT  = 6;
	localparam int YOVF_BIT  = 7;

	// movement clamp before doubling
	localparam int DELTA_LIM = 32;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic signed [DELTA_W-1:0] delta_x;
		logic signed [DELTA_W-1:0] delta_y;
		logic [BTN_W-1:0]          buttons;
		logic [POS_OUT_W-1:0]      pos_x;
		logic [POS_OUT_W-1:0]      pos_y;
	} result_t;

endpackage

FILE: sv/ps2_mouse_packet_decoder_top.sv
`timescale 1ns / 1ps

`include "ps2_mouse_packet_decoder_top_assert.svh"

// PS/2 mouse packet decoder with absolute cursor.
//
// Input channel (in_valid / in_stall): one transaction per mouse byte (op = byte)
// or a restart (op = restart), which drops any partial packet and centres the
// cursor on the configured screen. Output channel (out_valid / out_stall): one
// transaction per good three-byte packet, carrying doubled deltas, buttons and
// the new cursor position. Resync and overflow packets give nothing.
// Screen size lives in two APB registers (width at 0x0, height at 0x4); write
// them only while the block is idle.
//
// Timing: an accepted item waits in the input register, is decoded by a
// single pass of logic and lands in the result register, which offers it.
// One item per cycle is taken whilst the result register is free or being
// drained.
// Stall: a held result blocks the decode stage; the input register then acts
// as a skid, taking one more item before in_stall rises.
// Reset: partial packet dropped, cursor at the centre of 1024 x 768, both
// registers back to 1024 and 768, both channels empty.
module ps2_mouse_packet_decoder_top
	import pmpd_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// APB configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      op,
	input  logic [7:0]                data_byte,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DELTA_W-1:0] delta_x,
	output logic signed [DELTA_W-1:0] delta_y,
	output logic [BTN_W-1:0]          buttons,
	output logic [POS_OUT_W-1:0]      pos_x,
	output logic [POS_OUT_W-1:0]      pos_y
);

	// compare width: room for the larger of cursor and size, plus sign and carry
	localparam int CW    = ((POSITION_BITS > SIZE_W) ? POSITION_BITS : SIZE_W) + 2;
	localparam int MAXP  = (1 << POSITION_BITS) - 1;
	localparam int CX_RST = ((RESET_WIDTH / 2) > MAXP) ? MAXP : (RESET_WIDTH / 2);
	localparam int CY_RST = ((RESET_HEIGHT / 2) > MAXP) ? MAXP : (RESET_HEIGHT / 2);
	localparam logic [POSITION_BITS-1:0] CUR_X_RST = POSITION_BITS'(CX_RST);
	localparam logic [POSITION_BITS-1:0] CUR_Y_RST = POSITION_BITS'(CY_RST);
	localparam logic [CW-1:0] MAX_POS = CW'(MAXP);

	// configuration registers
	logic [SIZE_W-1:0] width_q, height_q;
	logic              cfg_wr;

	// input register
	logic  valid_s1;
	logic  op_s1;
	byte_t byte_s1;

	// decoder state
	byte_t                    held_q [2];
	logic [1:0]               count_q;
	logic [POSITION_BITS-1:0] cur_x_q, cur_y_q;

	// next state
	byte_t                    held_d [2];
	logic [1:0]               count_d;
	logic [POSITION_BITS-1:0] cur_x_d, cur_y_d;
	logic                     emit;

	// result register
	logic    valid_s2;
	result_t res_s2;
	result_t res_d;

	logic in_fire, advance;

	// centre of a screen axis, limited to the cursor range
	function automatic logic [POSITION_BITS-1:0] centre_of(input logic [SIZE_W-1:0] size);
		logic [CW-1:0] c;
		c = CW'(size[SIZE_W-1:1]);
		if (c > MAX_POS)
			c = MAX_POS;
		return c[POSITION_BITS-1:0];
	endfunction

	// cursor step with clamp to [0, min(size-1, max cursor)]; zero size acts as one
	function automatic logic [POSITION_BITS-1:0] move_pos(
		input logic [POSITION_BITS-1:0] pos,
		input logic signed [DELTA_W-1:0] d,
		input logic [SIZE_W-1:0] size
	);
		logic [CW-1:0]        lim;
		logic signed [CW-1:0] n;
		logic [CW-1:0]        r;
		lim = (size == '0) ? '0 : CW'(size) - CW'(1);
		if (lim > MAX_POS)
			lim = MAX_POS;
		n = $signed({{(CW-POSITION_BITS){1'b0}}, pos})
			+ $signed({{(CW-DELTA_W){d[DELTA_W-1]}}, d});
		if (n < 0)
			r = '0;
		else if ($unsigned(n) > lim)
			r = lim;
		else
			r = $unsigned(n);
		return r[POSITION_BITS-1:0];
	endfunction

	// clamp a 9-bit movement to +/-32; result fits 7 bits signed
	function automatic logic signed [6:0] clamp_mv(input logic signed [8:0] m);
		logic signed [6:0] r;
		if (m > 9'sd32)
			r = 7'(DELTA_LIM);
		else if (m < -9'sd32)
			r = -7'(DELTA_LIM);
		else
			r = m[6:0];
		return r;
	endfunction

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_SCREEN_HEIGHT)
		? {{(DATA_W-SIZE_W){1'b0}}, height_q}
		: {{(DATA_W-SIZE_W){1'b0}}, width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(RESET_WIDTH);
			height_q <= SIZE_W'(RESET_HEIGHT);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_SCREEN_WIDTH)
				width_q <= pwdata[SIZE_W-1:0];
			else
				height_q <= pwdata[SIZE_W-1:0];
		end
	end

	// ---------------------------------------------------------------- handshake
	// Decode stage moves on unless a result is stuck in the output register.
	assign advance  = valid_s1 & ~(valid_s2 & out_stall);
	assign in_stall = valid_s1 & valid_s2 & out_stall;
	assign in_fire  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1   <= op;
			byte_s1 <= data_byte;
		end
	end

	// ---------------------------------------------------------------- decode
	always_comb begin
		logic              flags_ok;
		logic signed [6:0] mx, my, my_n;
		held_d[0] = held_q[0];
		held_d[1] = held_q[1];
		count_d   = count_q;
		cur_x_d   = cur_x_q;
		cur_y_d   = cur_y_q;
		emit      = 1'b0;

		// movement from held header, second byte and current byte
		mx   = clamp_mv($signed({held_q[0][XSIGN_BIT], held_q[1]}));
		my   = clamp_mv($signed({held_q[0][YSIGN_BIT], byte_s1}));
		my_n = -my;
		res_d.delta_x = {mx, 1'b0};
		res_d.delta_y = {my_n, 1'b0};
		res_d.buttons = held_q[0][BTN_W-1:0];
		flags_ok = ~held_q[0][XOVF_BIT] & ~held_q[0][YOVF_BIT];

		case (op_s1)
			OP_RESTART: begin
				count_d = '0;
				cur_x_d = centre_of(width_q);
				cur_y_d = centre_of(height_q);
			end
			OP_BYTE: begin
				if (!count_q[1]) begin
					held_d[count_q[0]] = byte_s1;
					count_d = count_q + 2'd1;
				end else begin
					count_d = '0;
					if (!held_q[0][SYNC_BIT]) begin
						// header lost: slide to the next byte that looks like one
						if (held_q[1][SYNC_BIT]) begin
							held_d[0] = held_q[1];
							held_d[1] = byte_s1;
							count_d   = 2'd2;
						end else if (byte_s1[SYNC_BIT]) begin
							held_d[0] = byte_s1;
							count_d   = 2'd1;
						end
					end else if (flags_ok) begin
						emit    = 1'b1;
						cur_x_d = move_pos(cur_x_q, res_d.delta_x, width_q);
						cur_y_d = move_pos(cur_y_q, res_d.delta_y, height_q);
					end
				end
			end
			default: begin
			end
		endcase

		// output positions are the low twelve bits of the cursor
		res_d.pos_x = POS_OUT_W'(cur_x_d);
		res_d.pos_y = POS_OUT_W'(cur_y_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cur_x_q <= CUR_X_RST;
			cur_y_q <= CUR_Y_RST;
		end else if (advance) begin
			count_q <= count_d;
			cur_x_q <= cur_x_d;
			cur_y_q <= cur_y_d;
		end
	end

	// header bytes: no reset, only read after being written
	always_ff @(posedge clk) begin
		if (advance) begin
			held_q[0] <= held_d[0];
			held_q[1] <= held_d[1];
		end
	end

	// ---------------------------------------------------------------- result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= emit;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			res_s2 <= res_d;
	end

	assign out_valid = valid_s2;
	assign delta_x   = res_s2.delta_x;
	assign delta_y   = res_s2.delta_y;
	assign buttons   = res_s2.buttons;
	assign pos_x     = res_s2.pos_x;
	assign pos_y     = res_s2.pos_y;

	// ---------------------------------------------------------------- checks
	`PMPD_NEVER(a_count_range, count_q == 2'd3, "byte count reached three")
	`PMPD_IMPLY(a_stall_cause, in_stall, valid_s1 && valid_s2 && out_stall,
		"input stalled without a held result")
	`PMPD_IMPLY(a_emit_full, advance && emit, op_s1 == OP_BYTE && count_q == 2'd2,
		"result from an incomplete packet")
	`PMPD_IMPLY_NEXT(a_restart_clears, advance && op_s1 == OP_RESTART, count_q == 2'd0,
		"restart left bytes held")

endmodule

FILE: tb/sv/pmpd_cursor_checker.sv
`timescale 1ns / 1ps

// Watches the APB port and both channels of the mouse packet decoder,
// tracks packet assembly and the cursor, and compares every output transaction.
module pmpd_cursor_checker
	import pmpd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic                      pready,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]         pwdata,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic                      op,
	input  logic [7:0]                data_byte,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic signed [DELTA_W-1:0] delta_x,
	input  logic signed [DELTA_W-1:0] delta_y,
	input  logic [BTN_W-1:0]          buttons,
	input  logic [POS_OUT_W-1:0]      pos_x,
	input  logic [POS_OUT_W-1:0]      pos_y,
	output int                        failures,
	output int                        pending
);

	localparam int CURSOR_MAX = (1 << POSITION_BITS_DEF) - 1;

	int      scr_w      = RESET_WIDTH;
	int      scr_h      = RESET_HEIGHT;
	byte_t   held [2]   = '{8'h00, 8'h00};
	int      held_count = 0;
	int      cur_x      = RESET_WIDTH / 2;
	int      cur_y      = RESET_HEIGHT / 2;
	int      fail_count = 0;
	int      pending_r  = 0;
	int      failures_r = 0;
	result_t expected_moves [$];

	assign pending  = pending_r;
	assign failures = failures_r;

	function automatic int centre_pos(input int size);
		int c;
		c = size / 2;
		return (c > CURSOR_MAX) ? CURSOR_MAX : c;
	endfunction

	// zero size behaves as one, so the coordinate is pinned at 0
	function automatic int far_limit(input int size);
		int lim;
		lim = (size == 0) ? 0 : size - 1;
		return (lim > CURSOR_MAX) ? CURSOR_MAX : lim;
	endfunction

	function automatic int scaled_move(input int d);
		int v;
		v = d;
		if (v > DELTA_LIM)
			v = DELTA_LIM;
		if (v < -DELTA_LIM)
			v = -DELTA_LIM;
		return 2 * v;
	endfunction

	function automatic int step_cursor(input int pos, input int d, input int size);
		int n;
		int lim;
		n   = pos + d;
		lim = far_limit(size);
		if (n < 0)
			n = 0;
		if (n > lim)
			n = lim;
		return n;
	endfunction

	task automatic track_mouse_byte(input logic o, input byte_t b);
		byte_t   flags;
		byte_t   b1;
		int      dx;
		int      dy;
		result_t mv;
		if (o == OP_RESTART) begin
			held_count = 0;
			cur_x      = centre_pos(scr_w);
			cur_y      = centre_pos(scr_h);
			return;
		end
		if (held_count < 2) begin
			held[held_count] = b;
			held_count++;
			return;
		end
		held_count = 0;
		flags      = held[0];
		b1         = held[1];
		// first byte out of sync: realign on the next held byte with the sync bit
		if (!flags[SYNC_BIT]) begin
			if (b1[SYNC_BIT]) begin
				held[0]    = b1;
				held[1]    = b;
				held_count = 2;
			end else if (b[SYNC_BIT]) begin
				held[0]    = b;
				held_count = 1;
			end
			return;
		end
		if (flags[XOVF_BIT] || flags[YOVF_BIT])
			return;
		dx = int'(b1) - (flags[XSIGN_BIT] ? 256 : 0);
		dy = (flags[YSIGN_BIT] ? 256 : 0) - int'(b);
		dx = scaled_move(dx);
		dy = scaled_move(dy);
		cur_x = step_cursor(cur_x, dx, scr_w);
		cur_y = step_cursor(cur_y, dy, scr_h);
		mv.delta_x = dx[DELTA_W-1:0];
		mv.delta_y = dy[DELTA_W-1:0];
		mv.buttons = flags[BTN_W-1:0];
		mv.pos_x   = cur_x[POS_OUT_W-1:0];
		mv.pos_y   = cur_y[POS_OUT_W-1:0];
		expected_moves.push_back(mv);
	endtask

	task automatic compare_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			fail_count++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	task automatic check_move();
		result_t want;
		if (expected_moves.size() == 0) begin
			fail_count++;
			$error("unexpected transaction: delta_x %0d delta_y %0d buttons %0d pos %0d,%0d",
				delta_x, delta_y, buttons, pos_x, pos_y);
			return;
		end
		want = expected_moves.pop_front();
		compare_field("delta_x", want.delta_x, delta_x);
		compare_field("delta_y", want.delta_y, delta_y);
		compare_field("buttons", want.buttons, buttons);
		compare_field("pos_x", want.pos_x, pos_x);
		compare_field("pos_y", want.pos_y, pos_y);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w      = RESET_WIDTH;
			scr_h      = RESET_HEIGHT;
			held_count = 0;
			cur_x      = centre_pos(RESET_WIDTH);
			cur_y      = centre_pos(RESET_HEIGHT);
			expected_moves.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_SCREEN_HEIGHT)
					scr_h = int'(pwdata[SIZE_W-1:0]);
				else
					scr_w = int'(pwdata[SIZE_W-1:0]);
			end
			if (out_valid && !out_stall)
				check_move();
			if (in_valid && !in_stall)
				track_mouse_byte(op, data_byte);
		end
		pending_r  <= expected_moves.size();
		failures_r <= fail_count;
	end

endmodule

FILE: tb/sv/tb_ps2_mouse_packet_decoder_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the PS/2 mouse packet decoder. A checker instance
// beside the DUT predicts and compares; this module only drives and judges.
module tb_ps2_mouse_packet_decoder_top;
	import pmpd_pkg::*;

	// idling behaviour of a phase
	typedef enum logic [1:0] {
		GAPS_NONE,
		GAPS_SENDER,
		GAPS_RECEIVER,
		GAPS_BOTH
	} gap_mode_t;

	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 240;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0]  pwdata    = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic               op        = OP_BYTE;
	byte_t              data_byte = 8'h00;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [DELTA_W-1:0] delta_x;
	logic signed [DELTA_W-1:0] delta_y;
	logic [BTN_W-1:0]          buttons;
	logic [POS_OUT_W-1:0]      pos_x;
	logic [POS_OUT_W-1:0]      pos_y;
	int                 failures;
	int                 pending;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// Screen sizes per phase: reset size, full cursor range, a single pixel,
	// zero (treated as one), beyond the cursor range, odd and skewed sizes,
	// and the reset size written back explicitly. Phase 0 keeps reset values.
	int        phase_w [NUM_PHASES]    = '{1024, 4096, 1, 0, 8191, 3, 640, 1024};
	int        phase_h [NUM_PHASES]    = '{768, 4096, 1, 0, 8191, 4097, 2, 768};
	gap_mode_t phase_gaps [NUM_PHASES] = '{GAPS_NONE, GAPS_SENDER, GAPS_RECEIVER,
		GAPS_BOTH, GAPS_NONE, GAPS_SENDER, GAPS_RECEIVER, GAPS_BOTH};

	// Directed bytes, run straight after the first restart:
	//   largest positive X, Y zero; largest negative X and Y with all buttons;
	//   small moves with Y sign; X overflow; Y overflow;
	//   resync onto the second held byte; resync onto the third byte;
	//   three bytes with no sync bit at all, so everything is dropped.
	byte_t directed_bytes [27] = '{
		8'h09, 8'hFF, 8'h00,
		8'h3F, 8'h00, 8'h00,
		8'h28, 8'h05, 8'hFB,
		8'h48, 8'h01, 8'h01,
		8'h88, 8'h01, 8'h01,
		8'h00, 8'h08, 8'h02, 8'h01,
		8'h00, 8'h00, 8'h0A, 8'h10, 8'hF0,
		8'h07, 8'h80, 8'h77
	};

	ps2_mouse_packet_decoder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.delta_x   (delta_x),
		.delta_y   (delta_y),
		.buttons   (buttons),
		.pos_x     (pos_x),
		.pos_y     (pos_y)
	);

	pmpd_cursor_checker u_cursor_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.delta_x   (delta_x),
		.delta_y   (delta_y),
		.buttons   (buttons),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.failures  (failures),
		.pending   (pending)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// hard stop; far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// First byte of a well-formed packet: sync bit set, overflow rare so that
	// most packets reach the cursor.
	function automatic byte_t rand_flags();
		byte_t f;
		f = 8'($urandom);
		f[SYNC_BIT] = 1'b1;
		if ($urandom_range(7) != 0)
			f[YOVF_BIT:XOVF_BIT] = 2'b00;
		return f;
	endfunction

	// Movement byte: small moves, full range, small negatives and the values
	// around the clamp points.
	function automatic byte_t rand_motion();
		byte_t picks [9] = '{8'h00, 8'h1F, 8'h20, 8'h21, 8'h80, 8'hDF, 8'hE0, 8'hE1, 8'hFF};
		case ($urandom_range(3))
			0: return 8'($urandom_range(40));
			1: return 8'($urandom);
			2: return 8'(256 - $urandom_range(1, 40));
			default: return picks[$urandom_range(8)];
		endcase
	endfunction

	// One input transaction; payload held until it is taken.
	task automatic send_item(input logic o, input byte_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		data_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop sending and wait until every predicted transaction has come out,
	// then let the pipeline settle.
	task automatic drain(input int settle);
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (settle) @(posedge clk);
	endtask

	// APB write: setup, then access until pready.
	task automatic write_reg(input logic idx, input int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly whole packets with random content; the rest is noise bytes,
	// restarts and truncated packets that knock the framing out of line.
	task automatic run_random(input int quota, input bit hold_midway);
		int sent;
		int r;
		bit held_off;
		sent     = 0;
		held_off = 1'b0;
		while (sent < quota) begin
			if (hold_midway && !held_off && sent >= quota / 2) begin
				drain(0);
				held_off = 1'b1;
			end
			r = $urandom_range(99);
			if (r < 3) begin
				send_item(OP_RESTART, 8'($urandom));
				sent += 1;
			end else if (r < 11) begin
				send_item(OP_BYTE, 8'($urandom));
				sent += 1;
			end else if (r < 17) begin
				send_item(OP_BYTE, rand_flags());
				send_item(OP_BYTE, rand_motion());
				sent += 2;
			end else begin
				send_item(OP_BYTE, rand_flags());
				send_item(OP_BYTE, rand_motion());
				send_item(OP_BYTE, rand_motion());
				sent += 3;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			// registers only change with the DUT idle
			if (p != 0) begin
				drain(4);
				write_reg(REG_SCREEN_WIDTH, phase_w[p]);
				write_reg(REG_SCREEN_HEIGHT, phase_h[p]);
			end
			case (phase_gaps[p])
				GAPS_SENDER: begin
					send_idle_pct  <= 83;
					recv_stall_pct <= 0;
				end
				GAPS_RECEIVER: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 83;
				end
				GAPS_BOTH: begin
					send_idle_pct  <= 22;
					recv_stall_pct <= 22;
				end
				default: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 0;
				end
			endcase
			// recentre on the new screen before moving about
			send_item(OP_RESTART, 8'($urandom));
			if (p == 0) begin
				foreach (directed_bytes[i])
					send_item(OP_BYTE, directed_bytes[i]);
				send_item(OP_RESTART, 8'h00);
			end
			// phase 1 also pauses halfway until the output side is empty
			run_random(ITEMS_PER_PHASE, p == 1);
		end

		drain(8);
		if (failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/pmpd_pkg.sv
sv/ps2_mouse_packet_decoder_top.sv
tb/sv/pmpd_cursor_checker.sv
tb/sv/tb_ps2_mouse_packet_decoder_top.sv
